### rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int DATA_W    = 32;
  localparam int RAD_W     = DATA_W + 4;
  localparam int X_W       = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int NUM_W     = DATA_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int QB        = DATA_W + 1;
  localparam int NN_W      = NUM_W + FRAC_BITS;
  localparam int CMP_W     = DEN_W + QB;

  // which quaternion component carries the root
  typedef enum logic [3:0] {
    SEL_W = 4'b0001,
    SEL_X = 4'b0010,
    SEL_Y = 4'b0100,
    SEL_Z = 4'b1000
  } sel_t;

  typedef struct packed {
    sel_t                     sel;
    logic signed [NUM_W-1:0]  num_a;
    logic signed [NUM_W-1:0]  num_b;
    logic signed [NUM_W-1:0]  num_c;
  } side_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [QB-1:0]   q;
  } lane_t;

endpackage

### rtl/rmq_prep.sv
module rmq_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic signed [31:0]         m00, m01, m02,
  input  logic signed [31:0]         m10, m11, m12,
  input  logic signed [31:0]         m20, m21, m22,
  output logic                       vld_r,
  output logic [rmq_pkg::X_W-1:0]    x_r,
  output rmq_pkg::side_t             side_r
);
  import rmq_pkg::*;

  localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) <<< FRAC_BITS;

  logic signed [RAD_W-1:0] d0, d1, d2, trace, rad;
  logic [X_W-1:0]          x_nxt;
  side_t                   side_nxt;

  function automatic logic signed [NUM_W-1:0] sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    sub = NUM_W'(a) - NUM_W'(b);
  endfunction

  function automatic logic signed [NUM_W-1:0] add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    add = NUM_W'(a) + NUM_W'(b);
  endfunction

  always_comb begin
    d0 = RAD_W'(m00);
    d1 = RAD_W'(m11);
    d2 = RAD_W'(m22);
    trace = d0 + d1 + d2;
    if (trace > 0) begin
      side_nxt.sel   = SEL_W;
      rad            = trace + ONE;
      side_nxt.num_a = sub(m21, m12);
      side_nxt.num_b = sub(m02, m20);
      side_nxt.num_c = sub(m10, m01);
    end else if (m22 > ((m11 > m00) ? m11 : m00)) begin
      side_nxt.sel   = SEL_Z;
      rad            = d2 - (d0 + d1) + ONE;
      side_nxt.num_a = sub(m10, m01);
      side_nxt.num_b = add(m02, m20);
      side_nxt.num_c = add(m12, m21);
    end else if (m11 > m00) begin
      side_nxt.sel   = SEL_Y;
      rad            = d1 - (d2 + d0) + ONE;
      side_nxt.num_a = sub(m02, m20);
      side_nxt.num_b = add(m21, m12);
      side_nxt.num_c = add(m01, m10);
    end else begin
      side_nxt.sel   = SEL_X;
      rad            = d0 - (d1 + d2) + ONE;
      side_nxt.num_a = sub(m21, m12);
      side_nxt.num_b = add(m10, m01);
      side_nxt.num_c = add(m20, m02);
    end
    x_nxt = (rad > 0) ? (X_W'(rad) << FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    side_r <= side_nxt;
  end

endmodule

### rtl/rmq_sqrt.sv
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [rmq_pkg::X_W-1:0]     x_in,
  input  rmq_pkg::side_t              side_in,
  output logic                        vld_o,
  output logic [rmq_pkg::ROOT_W-1:0]  root_o,
  output rmq_pkg::side_t              side_o
);
  import rmq_pkg::*;

  // one root bit per stage
  logic [ROOT_W-1:0] vld_r;
  logic [X_W-1:0]    x_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar t = 0; t < ROOT_W; t++) begin : g_stg
    logic              v_p;
    logic [X_W-1:0]    x_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    side_t             side_p;
    logic [REM_W+1:0]  cand, trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (t == 0) begin : g_first
      assign v_p    = in_vld;
      assign x_p    = x_in;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = vld_r[t-1];
      assign x_p    = x_r[t-1];
      assign rem_p  = rem_r[t-1];
      assign root_p = root_r[t-1];
      assign side_p = side_r[t-1];
    end

    always_comb begin
      cand  = {rem_p, x_p[X_W-1 -: 2]};
      trial = {2'b00, root_p, 2'b01};
      if (cand >= trial) begin
        rem_nxt  = REM_W'(cand - trial);
        root_nxt = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cand[REM_W-1:0];
        root_nxt = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[t] <= 1'b0;
      end else begin
        vld_r[t] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      x_r[t]    <= {x_p[X_W-3:0], 2'b00};
      rem_r[t]  <= rem_nxt;
      root_r[t] <= root_nxt;
      side_r[t] <= side_p;
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

### rtl/rmq_div.sv
module rmq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [rmq_pkg::ROOT_W-1:0]  root_in,
  input  rmq_pkg::side_t              side_in,
  output logic                        vld_o,
  output logic [rmq_pkg::ROOT_W-1:0]  root_o,
  output rmq_pkg::sel_t               sel_o,
  output rmq_pkg::lane_t              lane_o [3]
);
  import rmq_pkg::*;

  // setup stage: magnitude, dividend, divisor, overflow per lane
  logic              s_vld_r;
  logic [ROOT_W-1:0] s_root_r;
  sel_t              s_sel_r;
  logic [DEN_W-1:0]  s_den_r;
  logic [NN_W-1:0]   s_n_r   [3];
  logic              s_neg_r [3];
  logic              s_ovf_r [3];

  logic signed [NUM_W-1:0] num [3];
  logic [DEN_W-1:0]        den_nxt;
  logic [NN_W-1:0]         n_nxt   [3];
  logic [NUM_W-1:0]        mag     [3];
  logic                    ovf_nxt [3];

  always_comb begin
    num[0]  = side_in.num_a;
    num[1]  = side_in.num_b;
    num[2]  = side_in.num_c;
    den_nxt = {root_in, 1'b0};
    for (int l = 0; l < 3; l++) begin
      mag[l]     = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
      n_nxt[l]   = (NN_W'(mag[l]) << FRAC_BITS) + NN_W'(root_in);
      ovf_nxt[l] = NN_W'(n_nxt[l] >> QB) >= NN_W'(den_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_root_r <= root_in;
    s_sel_r  <= side_in.sel;
    s_den_r  <= den_nxt;
    for (int l = 0; l < 3; l++) begin
      s_n_r[l]   <= n_nxt[l];
      s_neg_r[l] <= num[l][NUM_W-1];
      s_ovf_r[l] <= ovf_nxt[l];
    end
  end

  // restoring division, one quotient bit per stage, three lanes abreast
  logic [QB-1:0]     vld_r;
  logic [ROOT_W-1:0] root_r [QB];
  sel_t              sel_r  [QB];
  logic [DEN_W-1:0]  den_r  [QB];
  logic [NN_W-1:0]   rem_r  [QB][3];
  lane_t             lane_r [QB][3];

  for (genvar g = 0; g < QB; g++) begin : g_stg
    localparam int SH = QB - 1 - g;
    logic              v_p;
    logic [ROOT_W-1:0] root_p;
    sel_t              sel_p;
    logic [DEN_W-1:0]  den_p;
    logic [NN_W-1:0]   rem_p  [3];
    lane_t             lane_p [3];
    logic [CMP_W-1:0]  dsh;
    logic [NN_W-1:0]   rem_nxt  [3];
    lane_t             lane_nxt [3];

    if (g == 0) begin : g_first
      assign v_p    = s_vld_r;
      assign root_p = s_root_r;
      assign sel_p  = s_sel_r;
      assign den_p  = s_den_r;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l]  = s_n_r[l];
        assign lane_p[l] = '{neg: s_neg_r[l], ovf: s_ovf_r[l], q: '0};
      end
    end else begin : g_next
      assign v_p    = vld_r[g-1];
      assign root_p = root_r[g-1];
      assign sel_p  = sel_r[g-1];
      assign den_p  = den_r[g-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l]  = rem_r[g-1][l];
        assign lane_p[l] = lane_r[g-1][l];
      end
    end

    always_comb begin
      dsh = CMP_W'(den_p) << SH;
      for (int l = 0; l < 3; l++) begin
        lane_nxt[l] = lane_p[l];
        if (CMP_W'(rem_p[l]) >= dsh) begin
          rem_nxt[l]        = NN_W'(CMP_W'(rem_p[l]) - dsh);
          lane_nxt[l].q[SH] = 1'b1;
        end else begin
          rem_nxt[l] = rem_p[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      root_r[g] <= root_p;
      sel_r[g]  <= sel_p;
      den_r[g]  <= den_p;
      for (int l = 0; l < 3; l++) begin
        rem_r[g][l]  <= rem_nxt[l];
        lane_r[g][l] <= lane_nxt[l];
      end
    end
  end

  assign vld_o  = vld_r[QB-1];
  assign root_o = root_r[QB-1];
  assign sel_o  = sel_r[QB-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign lane_o[l] = lane_r[QB-1][l];
  end

endmodule

### rtl/rotation_matrix_to_quaternion_unit.sv
// A request accepted at one clock edge passes through these pipeline registers in order
// (1 setup stage, 32 square-root stages, 1 divide setup, 33 divide stages, 1 output).
// Throughput: one request per cycle; busy is never raised and results cannot be stalled.
// The root and the three quotient lanes are fully pipelined, one bit per stage.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
module rotation_matrix_to_quaternion_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_elem_r0c0,
  input  logic signed [31:0] in_elem_r0c1,
  input  logic signed [31:0] in_elem_r0c2,
  input  logic signed [31:0] in_elem_r1c0,
  input  logic signed [31:0] in_elem_r1c1,
  input  logic signed [31:0] in_elem_r1c2,
  input  logic signed [31:0] in_elem_r2c0,
  input  logic signed [31:0] in_elem_r2c1,
  input  logic signed [31:0] in_elem_r2c2,
  output logic               out_valid,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w
);
  import rmq_pkg::*;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic              p_vld;
  logic [X_W-1:0]    p_x;
  side_t             p_side;
  logic              r_vld;
  logic [ROOT_W-1:0] r_root;
  side_t             r_side;
  logic              d_vld;
  logic [ROOT_W-1:0] d_root;
  sel_t              d_sel;
  lane_t             d_lane [3];

  logic              vld_r;
  logic [DATA_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic [DATA_W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic [DATA_W-1:0] half, fa, fb, fc;
  logic [ROOT_W:0]   half_w;
  logic              zero_root;

  assign busy = 1'b0;

  rmq_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start),
    .m00    (in_elem_r0c0), .m01 (in_elem_r0c1), .m02 (in_elem_r0c2),
    .m10    (in_elem_r1c0), .m11 (in_elem_r1c1), .m12 (in_elem_r1c2),
    .m20    (in_elem_r2c0), .m21 (in_elem_r2c1), .m22 (in_elem_r2c2),
    .vld_r  (p_vld),
    .x_r    (p_x),
    .side_r (p_side)
  );

  rmq_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p_vld),
    .x_in    (p_x),
    .side_in (p_side),
    .vld_o   (r_vld),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  rmq_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (r_vld),
    .root_in (r_root),
    .side_in (r_side),
    .vld_o   (d_vld),
    .root_o  (d_root),
    .sel_o   (d_sel),
    .lane_o  (d_lane)
  );

  function automatic logic [DATA_W-1:0] fin(input lane_t ln, input logic zr);
    logic [DATA_W-1:0] r;
    r = '0;
    if (zr) begin
      r = '0;
    end else if (!ln.neg) begin
      r = (ln.ovf || ln.q > QB'(SAT_MAX)) ? SAT_MAX : DATA_W'(ln.q);
    end else begin
      r = (ln.ovf || ln.q > QB'(SAT_MIN)) ? SAT_MIN : DATA_W'(-ln.q);
    end
    fin = r;
  endfunction

  always_comb begin
    zero_root = (d_root == '0);
    half_w    = ((ROOT_W+1)'(d_root) + 1'b1) >> 1;
    half      = (half_w > (ROOT_W+1)'(SAT_MAX)) ? SAT_MAX : DATA_W'(half_w);
    fa        = fin(d_lane[0], zero_root);
    fb        = fin(d_lane[1], zero_root);
    fc        = fin(d_lane[2], zero_root);
    unique case (d_sel)
      SEL_W: begin
        qx_nxt = fa; qy_nxt = fb; qz_nxt = fc; qw_nxt = half;
      end
      SEL_X: begin
        qx_nxt = half; qw_nxt = fa; qy_nxt = fb; qz_nxt = fc;
      end
      SEL_Y: begin
        qy_nxt = half; qw_nxt = fa; qz_nxt = fb; qx_nxt = fc;
      end
      SEL_Z: begin
        qz_nxt = half; qw_nxt = fa; qx_nxt = fb; qy_nxt = fc;
      end
      default: begin
        qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    qz_r <= qz_nxt;
    qw_r <= qw_nxt;
  end

  assign out_valid  = vld_r;
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;
  assign out_quat_w = qw_r;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##68 out_valid)
    else $error("request did not produce a result on time");

  // divide setup, 33 divide stages, output register
  a_root_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    r_vld |-> ##35 out_valid)
    else $error("root lost between square root and divider");

endmodule
